// ===== rtl/pnge_pkg.sv =====
// ----------------------------------------------------------------------------
// pnge_pkg
// Types, constants and helpers shared by the PNG stream encoder modules.
// ----------------------------------------------------------------------------
package pnge_pkg;

    localparam int DefMaxWidth  = 4096;
    localparam int DefMaxHeight = 4096;

    localparam int DimW       = 13;
    localparam int CmdQDepth  = 2;
    localparam int ApbAddrW   = 4;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COLOR  = 2'd2;

    // byte positions of the per-file byte program
    localparam logic [6:0] IDX_HDR      = 7'd0;   // signature, IHDR, IDAT head, zlib
    localparam logic [6:0] IDX_ROW      = 7'd43;  // stored block header and filter
    localparam logic [6:0] IDX_PIX      = 7'd49;  // red, green, blue
    localparam logic [6:0] IDX_PIX_END  = 7'd51;
    localparam logic [6:0] IDX_TRL      = 7'd52;  // Adler-32, IDAT CRC, IEND
    localparam logic [6:0] IDX_FILE_END = 7'd71;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } t_result;

    typedef struct packed {
        logic [6:0] start_idx;
        logic       trailer;
        logic       bfinal;
        t_pixel     pixel;
    } t_cmd;

    function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v, input int hi);
        logic [DimW-1:0] r;
        if (v == '0) begin
            r = DimW'(1);
        end else if (int'(v) > hi) begin
            r = DimW'(hi);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/pnge_front.sv =====
// ----------------------------------------------------------------------------
// pnge_front
// Accepts pixels, tracks file position and queues one byte-program command each.
// ----------------------------------------------------------------------------
module pnge_front import pnge_pkg::*; #(
    parameter int MAX_WIDTH  = DefMaxWidth,
    parameter int MAX_HEIGHT = DefMaxHeight
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_pixel          i_pixel,
    input  logic [DimW-1:0] i_width,
    input  logic [DimW-1:0] i_height,
    input  logic            i_full,
    output logic            o_push,
    output t_cmd            o_cmd
);

    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int RW   = $clog2(MAX_HEIGHT + 1);
    localparam int CMPW = 18;

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          r_header_sent, n_header_sent;
    logic          r_trailer_pending, n_trailer_pending;

    logic          hdr;
    logic [CW-1:0] col_cur;
    logic [RW-1:0] row_cur;
    logic          row_end, file_end;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    assign hdr      = !r_header_sent;
    assign col_cur  = hdr ? '0 : r_col;
    assign row_cur  = hdr ? '0 : r_row;
    assign row_end  = (CMPW'(col_cur) + CMPW'(1)) >= CMPW'(i_width);
    assign file_end = (CMPW'(row_cur) + CMPW'(1)) >= CMPW'(i_height);

    always_comb begin
        o_cmd.pixel       = i_pixel;
        o_cmd.bfinal      = file_end;
        o_cmd.trailer     = 1'b0;
        o_cmd.start_idx   = hdr ? IDX_HDR : ((col_cur == '0) ? IDX_ROW : IDX_PIX);
        n_col             = r_col;
        n_row             = r_row;
        n_header_sent     = r_header_sent;
        n_trailer_pending = r_trailer_pending;
        if (r_trailer_pending) begin
            // trailer of a one-pixel file: the pixel is dropped
            o_cmd.start_idx   = IDX_TRL;
            o_cmd.trailer     = 1'b1;
            n_trailer_pending = 1'b0;
            n_header_sent     = 1'b0;
            n_col             = '0;
            n_row             = '0;
        end else if (row_end && file_end) begin
            n_col = '0;
            n_row = '0;
            if (hdr) begin
                n_header_sent     = 1'b1;
                n_trailer_pending = 1'b1;
            end else begin
                o_cmd.trailer = 1'b1;
                n_header_sent = 1'b0;
            end
        end else if (row_end) begin
            n_header_sent = 1'b1;
            n_col         = '0;
            n_row         = row_cur + RW'(1);
        end else begin
            n_header_sent = 1'b1;
            n_col         = col_cur + CW'(1);
            n_row         = row_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col             <= '0;
            r_row             <= '0;
            r_header_sent     <= 1'b0;
            r_trailer_pending <= 1'b0;
        end else if (o_push) begin
            r_col             <= n_col;
            r_row             <= n_row;
            r_header_sent     <= n_header_sent;
            r_trailer_pending <= n_trailer_pending;
        end
    end

endmodule

// ===== rtl/pnge_fifo.sv =====
// ----------------------------------------------------------------------------
// pnge_fifo
// Short command queue between the pixel front end and the byte back end.
// ----------------------------------------------------------------------------
module pnge_fifo import pnge_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_not_empty,
    output t_cmd o_cmd
);

    localparam int PW = (CmdQDepth > 1) ? $clog2(CmdQDepth) : 1;
    localparam int NW = $clog2(CmdQDepth + 1);

    t_cmd          r_mem [CmdQDepth];
    logic [PW-1:0] r_wr, r_rd;
    logic [NW-1:0] r_cnt;

    assign o_full      = r_cnt == NW'(CmdQDepth);
    assign o_not_empty = r_cnt != '0;
    assign o_cmd       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(CmdQDepth - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(CmdQDepth - 1)) ? '0 : r_rd + PW'(1);
            end
            r_cnt <= r_cnt + NW'(i_push) - NW'(i_pop);
        end
    end

endmodule

// ===== rtl/pnge_back.sv =====
// ----------------------------------------------------------------------------
// pnge_back
// Walks each command's byte program, keeps CRC-32 and Adler-32, drives output.
// ----------------------------------------------------------------------------
module pnge_back import pnge_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  t_cmd            i_cmd,
    output logic            o_pop,
    input  logic [DimW-1:0] i_width,
    input  logic [DimW-1:0] i_height,
    input  logic [2:0]      i_color_type,
    output logic            o_valid,
    input  logic            i_ready,
    output t_result         o_result
);

    localparam logic [1:0]  KIND_RAW  = 2'd0;
    localparam logic [1:0]  KIND_CRC  = 2'd1;
    localparam logic [1:0]  KIND_DATA = 2'd2;
    localparam logic [63:0] SIG       = 64'h89504E470D0A1A0A;
    localparam logic [31:0] CRC_ONES  = 32'hFFFFFFFF;
    localparam logic [16:0] ADLER_MOD = 17'd65521;

    function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = w[31:24];
            2'd1:    b = w[23:16];
            2'd2:    b = w[15:8];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? 32'hEDB88320 : 32'd0);
        end
        return c;
    endfunction

    logic [6:0]  r_idx;
    logic        r_started;
    logic [31:0] r_crc;
    logic [15:0] r_adler_lo, r_adler_hi;
    logic [31:0] r_idat_len;
    logic        r_out_valid;
    t_result     r_out;

    logic [14:0] linelen;
    logic [14:0] linelen_n;
    logic [27:0] idat_prod;
    logic        advance;
    logic [6:0]  idx, end_idx;
    logic [7:0]  cur_byte;
    logic [1:0]  kind;
    logic        crc_init;
    logic [31:0] crc_base, crc_next;
    logic [16:0] lo_sum, hi_sum;
    logic [15:0] lo_next, hi_next;

    assign linelen   = 15'(i_width) * 15'd3 + 15'd1;
    assign linelen_n = ~linelen;
    assign idat_prod = 28'(i_height) * 28'(linelen + 15'd5);

    assign advance = i_cmd_valid && (!r_out_valid || i_ready);
    assign idx     = r_started ? r_idx : i_cmd.start_idx;
    assign end_idx = i_cmd.trailer ? IDX_FILE_END : IDX_PIX_END;
    assign o_pop   = advance && (idx == end_idx);

    always_comb begin
        cur_byte = 8'd0;
        kind     = KIND_CRC;
        crc_init = 1'b0;
        if (idx < 7'd8) begin
            cur_byte = SIG[63 - 8 * int'(idx[2:0]) -: 8];
            kind     = KIND_RAW;
        end else if (idx < 7'd12) begin
            cur_byte = be_byte(32'd13, 2'(idx - 7'd8));
            kind     = KIND_RAW;
        end else if (idx < 7'd16) begin
            cur_byte = be_byte(32'h49484452, 2'(idx - 7'd12));
            crc_init = idx == 7'd12;
        end else if (idx < 7'd20) begin
            cur_byte = be_byte(32'(i_width), 2'(idx - 7'd16));
        end else if (idx < 7'd24) begin
            cur_byte = be_byte(32'(i_height), 2'(idx - 7'd20));
        end else if (idx == 7'd24) begin
            cur_byte = 8'd8;
        end else if (idx == 7'd25) begin
            cur_byte = 8'(i_color_type);
        end else if (idx < 7'd29) begin
            cur_byte = 8'd0;
        end else if (idx < 7'd33) begin
            cur_byte = be_byte(~r_crc, 2'(idx - 7'd29));
            kind     = KIND_RAW;
        end else if (idx < 7'd37) begin
            cur_byte = be_byte(r_idat_len, 2'(idx - 7'd33));
            kind     = KIND_RAW;
        end else if (idx < 7'd41) begin
            cur_byte = be_byte(32'h49444154, 2'(idx - 7'd37));
            crc_init = idx == 7'd37;
        end else if (idx == 7'd41) begin
            cur_byte = 8'h78;
        end else if (idx == 7'd42) begin
            cur_byte = 8'h01;
        end else if (idx == 7'd43) begin
            cur_byte = {7'd0, i_cmd.bfinal};
        end else if (idx == 7'd44) begin
            cur_byte = linelen[7:0];
        end else if (idx == 7'd45) begin
            cur_byte = {1'b0, linelen[14:8]};
        end else if (idx == 7'd46) begin
            cur_byte = linelen_n[7:0];
        end else if (idx == 7'd47) begin
            // NLEN high byte: bit 15 of the complement is always set
            cur_byte = {1'b1, linelen_n[14:8]};
        end else if (idx == 7'd48) begin
            cur_byte = 8'd0;
            kind     = KIND_DATA;
        end else if (idx == 7'd49) begin
            cur_byte = i_cmd.pixel.red;
            kind     = KIND_DATA;
        end else if (idx == 7'd50) begin
            cur_byte = i_cmd.pixel.green;
            kind     = KIND_DATA;
        end else if (idx == 7'd51) begin
            cur_byte = i_cmd.pixel.blue;
            kind     = KIND_DATA;
        end else if (idx < 7'd56) begin
            cur_byte = be_byte({r_adler_hi, r_adler_lo}, 2'(idx - 7'd52));
        end else if (idx < 7'd60) begin
            cur_byte = be_byte(~r_crc, 2'(idx - 7'd56));
            kind     = KIND_RAW;
        end else if (idx < 7'd64) begin
            cur_byte = 8'd0;
            kind     = KIND_RAW;
        end else if (idx < 7'd68) begin
            cur_byte = be_byte(32'h49454E44, 2'(idx - 7'd64));
            crc_init = idx == 7'd64;
        end else begin
            cur_byte = be_byte(~r_crc, 2'(idx - 7'd68));
            kind     = KIND_RAW;
        end
    end

    assign crc_base = crc_init ? CRC_ONES : r_crc;
    assign crc_next = crc_byte(crc_base, cur_byte);

    assign lo_sum  = 17'(r_adler_lo) + 17'(cur_byte);
    assign lo_next = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : 16'(lo_sum);
    assign hi_sum  = 17'(r_adler_hi) + 17'(lo_next);
    assign hi_next = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : 16'(hi_sum);

    always_ff @(posedge i_clk) begin
        r_idat_len <= 32'(idat_prod) + 32'd6;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_started   <= 1'b0;
            r_crc       <= CRC_ONES;
            r_adler_lo  <= 16'd1;
            r_adler_hi  <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                if (o_pop) begin
                    r_started <= 1'b0;
                end else begin
                    r_started <= 1'b1;
                    r_idx     <= idx + 7'd1;
                end
                if (idx == IDX_FILE_END) begin
                    // file done: start the next one clean
                    r_crc      <= CRC_ONES;
                    r_adler_lo <= 16'd1;
                    r_adler_hi <= 16'd0;
                end else begin
                    if (kind != KIND_RAW) begin
                        r_crc <= crc_next;
                    end
                    if (kind == KIND_DATA) begin
                        r_adler_lo <= lo_next;
                        r_adler_hi <= hi_next;
                    end
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.file_byte   <= cur_byte;
            r_out.end_of_file <= idx == IDX_FILE_END;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_started_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> i_cmd_valid)
        else $error("byte program in progress with an empty command queue");

    a_crc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && idx == IDX_FILE_END) |=> (r_crc == CRC_ONES && r_adler_lo == 16'd1))
        else $error("checksums not cleared after the last byte of a file");

    a_adler_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (17'(r_adler_lo) < ADLER_MOD) && (17'(r_adler_hi) < ADLER_MOD))
        else $error("Adler-32 sums out of range");

    a_eof_at_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && idx == IDX_FILE_END) |-> o_pop)
        else $error("last file byte without the command retiring");

endmodule

// ===== rtl/png_uncompressed_stream_encoder_top.sv =====
// ----------------------------------------------------------------------------
// png_uncompressed_stream_encoder_top
// RGB pixel stream in, complete uncompressed 8-bit truecolour PNG file out.
// ----------------------------------------------------------------------------
// One byte leaves per cycle unless i_ready holds the output or the queue is empty;
// a pixel inside a row takes 3 bytes, the first pixel of a row 9, and the first
// pixel of a file 52; the last pixel adds 20 trailer bytes (Adler-32, IDAT CRC,
// IEND). The byte sequencer in the back end sets these byte counts; the two-entry
// command queue holds the pixel in progress and one more behind it. For a
// one-by-one image the trailer is sent on the following pixel, which is dropped.
// Width and height are clamped to 1..MAX; registers sit at byte addresses
// 0 (width), 4 (height) and 8 (color type).
module png_uncompressed_stream_encoder_top import pnge_pkg::*; #(
    parameter int MAX_WIDTH  = DefMaxWidth,
    parameter int MAX_HEIGHT = DefMaxHeight
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_pixel              i_pixel,
    output logic                o_valid,
    input  logic                i_ready,
    output t_result             o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [DimW-1:0] r_image_width, r_image_height;
    logic [2:0]      r_color_type;
    logic [DimW-1:0] width, height;
    logic            wr_en;

    logic push, full, pop, not_empty;
    t_cmd push_cmd, head_cmd;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= DimW'(1);
            r_image_height <= DimW'(1);
            r_color_type   <= 3'd2;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_WIDTH:  r_image_width  <= pwdata[DimW-1:0];
                REG_HEIGHT: r_image_height <= pwdata[DimW-1:0];
                REG_COLOR:  r_color_type   <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(r_image_width);
            REG_HEIGHT: prdata = 32'(r_image_height);
            REG_COLOR:  prdata = 32'(r_color_type);
            default:    prdata = 32'd0;
        endcase
    end

    assign width  = clamp_dim(r_image_width, MAX_WIDTH);
    assign height = clamp_dim(r_image_height, MAX_HEIGHT);

    pnge_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_pixel  (i_pixel),
        .i_width  (width),
        .i_height (height),
        .i_full   (full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    pnge_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (push_cmd),
        .o_full      (full),
        .i_pop       (pop),
        .o_not_empty (not_empty),
        .o_cmd       (head_cmd)
    );

    pnge_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (not_empty),
        .i_cmd        (head_cmd),
        .o_pop        (pop),
        .i_width      (width),
        .i_height     (height),
        .i_color_type (r_color_type),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result     (o_result)
    );

endmodule
